// ----- hw/rtl/rdc_pkg.sv -----
// types, constants and helpers shared by the radix digit converter
`default_nettype none

package rdc_pkg;

    // field widths fixed by the item format
    localparam int VALUE_FIELD_W = 64;
    localparam int RADIX_W       = 5;
    localparam int CHAR_W        = 7;
    localparam int DIGIT_W       = 4;

    // sizing of the datapath and the digit store
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;
    localparam int ADDR_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    // the divider consumes this many dividend bits per cycle
    localparam int STEP_BITS = 8;
    localparam int CHUNKS    = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int WORK_W    = CHUNKS * STEP_BITS;
    localparam int STEP_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    // radix limits and character codes
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
    localparam logic [DIGIT_W-1:0] DECIMAL_TEN = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(8'h61);

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value;
        logic [RADIX_W-1:0]       radix;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              bad_radix;
        logic              last;
    } t_out_item;

    // commands from the controller to the divider
    typedef struct packed {
        logic                     load;
        logic                     next;
        logic [VALUE_FIELD_W-1:0] value;
        logic [RADIX_W-1:0]       radix;
    } t_div_cmd;

    // divider status back to the controller
    typedef struct packed {
        logic               done;
        logic               quot_zero;
        logic [DIGIT_W-1:0] digit;
    } t_div_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_BAD,
        S_RD,
        S_EMIT
    } t_state;

    // digit value to lower-case ascii
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DECIMAL_TEN);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rdc_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/rdc_divider.sv -----
// iterative divider: one digit by long division, a byte of dividend per cycle
`default_nettype none

module rdc_divider (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rdc_pkg::t_div_cmd i_cmd,
    output rdc_pkg::t_div_stat     o_stat
);

    logic [rdc_pkg::WORK_W-1:0]  r_work;
    logic [rdc_pkg::WORK_W-1:0]  n_work;
    logic [rdc_pkg::DIGIT_W-1:0] r_rem;
    logic [rdc_pkg::DIGIT_W-1:0] n_rem;
    logic [rdc_pkg::RADIX_W-1:0] r_radix;
    logic [rdc_pkg::STEP_W-1:0]  r_step;
    logic                        r_busy;
    logic                        r_done;
    logic [rdc_pkg::STEP_BITS-1:0] q_bits;

    // restoring division over the top byte of the working word
    always_comb begin
        logic [rdc_pkg::DIGIT_W:0]     t;
        logic [rdc_pkg::DIGIT_W-1:0]   rem;
        logic [rdc_pkg::STEP_BITS-1:0] bits;
        rem    = r_rem;
        bits   = r_work[rdc_pkg::WORK_W-1 -: rdc_pkg::STEP_BITS];
        q_bits = '0;
        for (int i = rdc_pkg::STEP_BITS - 1; i >= 0; i--) begin
            t = {rem, bits[i]};
            if (t >= r_radix) begin
                t         = t - r_radix;
                q_bits[i] = 1'b1;
            end
            rem = t[rdc_pkg::DIGIT_W-1:0];
        end
        n_rem  = rem;
        n_work = (r_work << rdc_pkg::STEP_BITS) | rdc_pkg::WORK_W'(q_bits);
    end

    // control: load a new value, or restart on the previous quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.load || i_cmd.next) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == rdc_pkg::STEP_W'(rdc_pkg::CHUNKS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers; the quotient shifts in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work  <= rdc_pkg::WORK_W'(i_cmd.value[rdc_pkg::VALUE_WIDTH-1:0]);
            r_radix <= i_cmd.radix;
            r_rem   <= '0;
        end else if (i_cmd.next) begin
            r_rem <= '0;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.quot_zero = (r_work == '0);
    assign o_stat.digit     = r_rem;

endmodule

`default_nettype wire

// ----- hw/rtl/radix_digit_converter_core.sv -----
// radix digit converter top level: control, digit store and output register
//
//  channel | direction | handshake            | payload
//  in      | sink      | i_in_valid/o_in_stall | i_in_item  (value, radix)
//  out     | source    | o_out_valid/i_out_stall | o_out_item (digit_char, bad_radix, last)
//
// each digit takes one pass of the divider over the dividend bytes; an item with n digits
// takes n divider passes, one store read and n transfers of read-out, most significant
// digit first. a bad radix gives one character with bad_radix set. one item is worked on
// at a time; o_in_stall is high until the last character is in the output register.
// output stall holds the read-out. reset is synchronous, active low, clears control state.
`default_nettype none

module radix_digit_converter_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rdc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rdc_pkg::t_out_item      o_out_item
);

    rdc_pkg::t_state    r_state;
    rdc_pkg::t_state    n_state;
    logic [rdc_pkg::ADDR_W-1:0]  r_cnt;
    logic [rdc_pkg::ADDR_W-1:0]  n_cnt;
    logic [rdc_pkg::ADDR_W-1:0]  r_idx;
    logic [rdc_pkg::ADDR_W-1:0]  n_idx;
    logic                        r_out_valid;
    rdc_pkg::t_out_item          r_out;
    rdc_pkg::t_div_cmd           div_cmd;
    rdc_pkg::t_div_stat          div_stat;
    logic                        in_fire;
    logic                        radix_ok;
    logic                        out_free;
    logic                        out_load;
    rdc_pkg::t_out_item          out_next;
    logic                        ram_we;
    logic [rdc_pkg::ADDR_W-1:0]  ram_raddr;
    logic [rdc_pkg::DIGIT_W-1:0] ram_rdata;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign radix_ok = (i_in_item.radix >= rdc_pkg::RADIX_MIN)
                   && (i_in_item.radix <= rdc_pkg::RADIX_MAX);
    assign out_free = !r_out_valid || !i_out_stall;

    rdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_stat  (div_stat)
    );

    rdc_ram #(
        .WIDTH (rdc_pkg::DIGIT_W),
        .DEPTH (rdc_pkg::MAX_DIGITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (div_stat.digit),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state, divider commands, store access and output load
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_idx           = r_idx;
        div_cmd.load    = 1'b0;
        div_cmd.next    = 1'b0;
        div_cmd.value   = i_in_item.value;
        div_cmd.radix   = i_in_item.radix;
        ram_we          = 1'b0;
        ram_raddr       = r_idx;
        out_load        = 1'b0;
        out_next.digit_char = rdc_pkg::to_ascii(ram_rdata);
        out_next.bad_radix  = 1'b0;
        out_next.last       = (r_idx == '0);
        o_in_stall      = (r_state != rdc_pkg::S_IDLE);
        unique case (r_state)
            rdc_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_cnt = '0;
                    if (radix_ok) begin
                        div_cmd.load = 1'b1;
                        n_state      = rdc_pkg::S_DIV;
                    end else begin
                        n_state = rdc_pkg::S_BAD;
                    end
                end
            end
            rdc_pkg::S_DIV: begin
                if (div_stat.done) begin
                    ram_we = 1'b1;
                    if (div_stat.quot_zero
                        || (r_cnt == rdc_pkg::ADDR_W'(rdc_pkg::MAX_DIGITS - 1))) begin
                        n_idx   = r_cnt;
                        n_state = rdc_pkg::S_RD;
                    end else begin
                        n_cnt        = r_cnt + 1'b1;
                        div_cmd.next = 1'b1;
                    end
                end
            end
            rdc_pkg::S_BAD: begin
                out_next.digit_char = '0;
                out_next.bad_radix  = 1'b1;
                out_next.last       = 1'b1;
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = rdc_pkg::S_IDLE;
                end
            end
            rdc_pkg::S_RD: begin
                // read of the top digit is in flight
                n_state = rdc_pkg::S_EMIT;
            end
            rdc_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_idx == '0) begin
                        n_state = rdc_pkg::S_IDLE;
                    end else begin
                        n_idx     = r_idx - 1'b1;
                        ram_raddr = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = rdc_pkg::S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rdc_pkg::S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    // output register, free again once its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
